>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the encoder checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset
`define ASSERT_ON(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Checked at every edge, reset included
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

>>> hw/rtl/pse_pkg.sv
// ----------------------------------------------------------------------------
// pse_pkg
// Types, constants and helper functions of the PNG stored RGB encoder.
// ----------------------------------------------------------------------------
package pse_pkg;

  localparam int unsigned MaxWidth  = 21844;
  localparam int unsigned MaxHeight = 16384;

  localparam logic [31:0] CRC_POLY  = 32'hEDB88320;
  localparam logic [31:0] CRC_SEED  = 32'hFFFFFFFF;
  localparam logic [16:0] ADLER_MOD = 17'd65521;

  localparam logic [7:0] PNG_SIG [0:7] = '{8'd137, 8'd80, 8'd78, 8'd71,
                                           8'd13, 8'd10, 8'd26, 8'd10};
  localparam logic [31:0] TYPE_IHDR = 32'h49484452;
  localparam logic [31:0] TYPE_IDAT = 32'h49444154;
  localparam logic [31:0] TYPE_IEND = 32'h49454E44;
  localparam logic [7:0]  ZLIB_CMF  = 8'h78;
  localparam logic [7:0]  ZLIB_FLG  = 8'h01;
  localparam logic [7:0]  IHDR_LEN  = 8'd13;
  localparam logic [7:0]  BIT_DEPTH = 8'd8;
  localparam logic [7:0]  COL_TYPE  = 8'd2;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;

  // last byte index of the header, row-header and trailer phases
  localparam logic [5:0] HDR_LAST  = 6'd42;
  localparam logic [5:0] ROWH_LAST = 6'd5;
  localparam logic [5:0] TRL_LAST  = 6'd19;

  typedef enum logic [1:0] {
    PH_HDR,
    PH_ROWH,
    PH_PIX,
    PH_TRL
  } phase_t;

  typedef struct packed {
    logic [7:0] pixel;
    logic       hdr;
    logic       row_start;
    logic       last_row;
    logic       img_end;
  } item_t;

  typedef struct packed {
    logic [14:0] eff_w;
    logic [14:0] eff_h;
    logic [15:0] stride;
    logic [31:0] idat_len;
  } geom_t;

  function automatic logic [7:0] byte_sel(input logic [31:0] v, input logic [1:0] k);
    logic [7:0] b;
    unique case (k)
      2'd0: b = v[31:24];
      2'd1: b = v[23:16];
      2'd2: b = v[15:8];
      2'd3: b = v[7:0];
    endcase
    return b;
  endfunction

  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] v;
    v = c ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      v = v[0] ? (CRC_POLY ^ (v >> 1)) : (v >> 1);
    end
    return v;
  endfunction

endpackage

>>> hw/rtl/pse_front.sv
// ----------------------------------------------------------------------------
// pse_front
// Holds the image geometry, takes pixel items, tags each with its row and
// file position and queues it for the byte sequencer.
// ----------------------------------------------------------------------------
module pse_front
  import pse_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [14:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_pixel_byte,
  output logic        head_valid,
  output item_t       head,
  input  logic        head_pop,
  output geom_t       geom
);

  logic [14:0] width_r, height_r;
  logic [14:0] eff_w, eff_h;
  logic [15:0] row_bytes;
  logic [31:0] idat_len_r;
  logic [15:0] bir_r, bir_nxt, bir_inc;
  logic [13:0] row_r, row_nxt;
  logic        hdr_sent_r, hdr_sent_nxt;
  logic        last_row, row_end, accept;
  item_t       entry;

  item_t       q_r [2];
  logic        wp_r, rp_r;
  logic [1:0]  cnt_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 15'd1;
      height_r <= 15'd1;
    end else if (cfg_valid) begin
      if (cfg_index == REG_WIDTH)  width_r  <= cfg_data;
      if (cfg_index == REG_HEIGHT) height_r <= cfg_data;
    end
  end

  always_comb begin
    if (width_r == '0)                     eff_w = 15'd1;
    else if (width_r > 15'(MaxWidth))      eff_w = 15'(MaxWidth);
    else                                   eff_w = width_r;
    if (height_r == '0)                    eff_h = 15'd1;
    else if (height_r > 15'(MaxHeight))    eff_h = 15'(MaxHeight);
    else                                   eff_h = height_r;
  end

  assign row_bytes = 16'({1'b0, eff_w} + {eff_w, 1'b0});

  // 6 + h * (3w + 6): zlib header, Adler, and per row 5 + stride
  always_ff @(posedge clk) begin
    idat_len_r <= 32'd6 + 32'(eff_h) * (32'(row_bytes) + 32'd6);
  end

  assign geom.eff_w    = eff_w;
  assign geom.eff_h    = eff_h;
  assign geom.stride   = row_bytes + 16'd1;
  assign geom.idat_len = idat_len_r;

  assign bir_inc  = bir_r + 16'd1;
  assign last_row = ({1'b0, row_r} + 15'd1) >= eff_h;
  assign row_end  = bir_inc >= row_bytes;
  assign in_ready = cnt_r != 2'd2;
  assign accept   = in_valid && in_ready;

  assign entry.pixel     = in_pixel_byte;
  assign entry.hdr       = !hdr_sent_r;
  assign entry.row_start = bir_r == '0;
  assign entry.last_row  = last_row;
  assign entry.img_end   = row_end && last_row;

  always_comb begin
    bir_nxt      = bir_r;
    row_nxt      = row_r;
    hdr_sent_nxt = hdr_sent_r;
    if (accept) begin
      hdr_sent_nxt = 1'b1;
      bir_nxt      = bir_inc;
      if (row_end) begin
        bir_nxt = '0;
        if (last_row) begin
          row_nxt      = '0;
          hdr_sent_nxt = 1'b0;
        end else begin
          row_nxt = row_r + 14'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bir_r      <= '0;
      row_r      <= '0;
      hdr_sent_r <= 1'b0;
    end else begin
      bir_r      <= bir_nxt;
      row_r      <= row_nxt;
      hdr_sent_r <= hdr_sent_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) q_r[wp_r] <= entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (accept)   wp_r <= !wp_r;
      if (head_pop) rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, accept} - {1'b0, head_pop};
    end
  end

  assign head_valid = cnt_r != '0;
  assign head       = q_r[rp_r];

endmodule

>>> hw/rtl/pse_back.sv
// ----------------------------------------------------------------------------
// pse_back
// Byte sequencer: expands each queued item into PNG stream bytes, one a
// cycle while not stalled, keeping the chunk CRC and the Adler-32 sums.
// ----------------------------------------------------------------------------
module pse_back
  import pse_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        head_valid,
  input  item_t       head,
  output logic        head_pop,
  input  geom_t       geom,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_run_last,
  output logic        out_file_end
);

  phase_t      phase_r, phase_nxt, cur_ph;
  logic [5:0]  idx_r, idx_nxt, cur_idx, k;
  logic        started_r, started_nxt;
  logic [31:0] crc_r, crc_nxt, crc_base, crc_out;
  logic [15:0] lo_r, hi_r, lo_nxt, hi_nxt;
  logic [16:0] lo_s, hi_s, lo_m;
  logic        out_valid_r, run_last_r, file_end_r;
  logic [7:0]  out_byte_r, byte_v;
  logic        feed, init, scan, done, fend, load;

  assign cur_ph  = started_r ? phase_r : (head.hdr ? PH_HDR :
                   (head.row_start ? PH_ROWH : PH_PIX));
  assign cur_idx = started_r ? idx_r : '0;
  assign crc_out = crc_r ^ CRC_SEED;
  assign load    = head_valid && (!out_valid_r || out_ready);

  always_comb begin
    byte_v = '0;
    feed   = 1'b1;
    init   = 1'b0;
    scan   = 1'b0;
    k      = '0;
    unique case (cur_ph)
      PH_HDR: begin
        if (cur_idx < 6'd8) begin
          byte_v = PNG_SIG[cur_idx[2:0]];
          feed   = 1'b0;
        end else if (cur_idx < 6'd12) begin
          byte_v = (cur_idx == 6'd11) ? IHDR_LEN : 8'd0;
          feed   = 1'b0;
        end else if (cur_idx < 6'd16) begin
          byte_v = byte_sel(TYPE_IHDR, cur_idx[1:0]);
          init   = cur_idx == 6'd12;
        end else if (cur_idx < 6'd20) begin
          byte_v = byte_sel({17'd0, geom.eff_w}, cur_idx[1:0]);
        end else if (cur_idx < 6'd24) begin
          byte_v = byte_sel({17'd0, geom.eff_h}, cur_idx[1:0]);
        end else if (cur_idx == 6'd24) begin
          byte_v = BIT_DEPTH;
        end else if (cur_idx == 6'd25) begin
          byte_v = COL_TYPE;
        end else if (cur_idx < 6'd29) begin
          byte_v = 8'd0;
        end else if (cur_idx < 6'd33) begin
          k      = cur_idx - 6'd29;
          byte_v = byte_sel(crc_out, k[1:0]);
          feed   = 1'b0;
        end else if (cur_idx < 6'd37) begin
          k      = cur_idx - 6'd33;
          byte_v = byte_sel(geom.idat_len, k[1:0]);
          feed   = 1'b0;
        end else if (cur_idx < 6'd41) begin
          k      = cur_idx - 6'd37;
          byte_v = byte_sel(TYPE_IDAT, k[1:0]);
          init   = cur_idx == 6'd37;
        end else if (cur_idx == 6'd41) begin
          byte_v = ZLIB_CMF;
        end else begin
          byte_v = ZLIB_FLG;
        end
      end
      PH_ROWH: begin
        unique case (cur_idx[2:0])
          3'd0:    byte_v = {7'd0, head.last_row};
          3'd1:    byte_v = geom.stride[7:0];
          3'd2:    byte_v = geom.stride[15:8];
          3'd3:    byte_v = ~geom.stride[7:0];
          3'd4:    byte_v = ~geom.stride[15:8];
          default: begin
            byte_v = 8'd0;
            scan   = 1'b1;
          end
        endcase
      end
      PH_PIX: begin
        byte_v = head.pixel;
        scan   = 1'b1;
      end
      PH_TRL: begin
        if (cur_idx < 6'd4) begin
          byte_v = byte_sel({hi_r, lo_r}, cur_idx[1:0]);
        end else if (cur_idx < 6'd8) begin
          byte_v = byte_sel(crc_out, cur_idx[1:0]);
          feed   = 1'b0;
        end else if (cur_idx < 6'd12) begin
          byte_v = 8'd0;
          feed   = 1'b0;
        end else if (cur_idx < 6'd16) begin
          byte_v = byte_sel(TYPE_IEND, cur_idx[1:0]);
          init   = cur_idx == 6'd12;
        end else begin
          byte_v = byte_sel(crc_out, cur_idx[1:0]);
          feed   = 1'b0;
        end
      end
    endcase
  end

  // sequencing across phases
  always_comb begin
    phase_nxt   = cur_ph;
    idx_nxt     = cur_idx + 6'd1;
    started_nxt = 1'b1;
    done        = 1'b0;
    fend        = 1'b0;
    unique case (cur_ph)
      PH_HDR: if (cur_idx == HDR_LAST) begin
        phase_nxt = head.row_start ? PH_ROWH : PH_PIX;
        idx_nxt   = '0;
      end
      PH_ROWH: if (cur_idx == ROWH_LAST) begin
        phase_nxt = PH_PIX;
        idx_nxt   = '0;
      end
      PH_PIX: begin
        phase_nxt = PH_TRL;
        idx_nxt   = '0;
        done      = !head.img_end;
      end
      PH_TRL: if (cur_idx == TRL_LAST) begin
        done = 1'b1;
        fend = 1'b1;
      end
    endcase
    if (done) started_nxt = 1'b0;
  end

  assign head_pop = load && done;

  assign crc_base = init ? CRC_SEED : crc_r;
  assign crc_nxt  = feed ? crc_byte(crc_base, byte_v) : crc_base;

  always_comb begin
    lo_s = {1'b0, lo_r} + {9'd0, byte_v};
    lo_m = (lo_s >= ADLER_MOD) ? lo_s - ADLER_MOD : lo_s;
    hi_s = {1'b0, hi_r} + lo_m;
    lo_nxt = lo_r;
    hi_nxt = hi_r;
    if (scan) begin
      lo_nxt = lo_m[15:0];
      hi_nxt = (hi_s >= ADLER_MOD) ? 16'(hi_s - ADLER_MOD) : hi_s[15:0];
    end
    if (fend) begin
      lo_nxt = 16'd1;
      hi_nxt = 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HDR;
      idx_r       <= '0;
      started_r   <= 1'b0;
      crc_r       <= CRC_SEED;
      lo_r        <= 16'd1;
      hi_r        <= 16'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        phase_r   <= phase_nxt;
        idx_r     <= idx_nxt;
        started_r <= started_nxt;
        crc_r     <= crc_nxt;
        lo_r      <= lo_nxt;
        hi_r      <= hi_nxt;
      end
      if (load)           out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte_r <= byte_v;
      run_last_r <= done;
      file_end_r <= fend;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_byte     = out_byte_r;
  assign out_run_last = run_last_r;
  assign out_file_end = file_end_r;

endmodule

>>> hw/rtl/png_stored_rgb_encoder.sv
// ----------------------------------------------------------------------------
// png_stored_rgb_encoder
// RGB8 pixel bytes in, complete PNG file out (stored deflate, one block
// per scanline).
// ----------------------------------------------------------------------------
//  channel | direction | payload
//  cfg     | in        | cfg_index (0 width, 1 height), cfg_data
//  in      | in        | in_pixel_byte
//  out     | out       | out_byte, out_run_last, out_file_end
//
//  One byte per cycle from the sequencer unless stalled; an item gives 1 byte,
//  7 at a row start, 43 more on the first item of a file, 20 more at the end.
//  A two-entry queue lets items be taken while the sequencer drains.
//  Synchronous active-low reset; no clearing pass. Both sides stall freely.
// ----------------------------------------------------------------------------
module png_stored_rgb_encoder
  import pse_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [14:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_pixel_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_run_last,
  output logic        out_file_end
);

  logic  head_valid, head_pop;
  item_t head;
  geom_t geom;

  pse_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_pixel_byte (in_pixel_byte),
    .head_valid    (head_valid),
    .head          (head),
    .head_pop      (head_pop),
    .geom          (geom)
  );

  pse_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head_valid   (head_valid),
    .head         (head),
    .head_pop     (head_pop),
    .geom         (geom),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .out_run_last (out_run_last),
    .out_file_end (out_file_end)
  );

endmodule

>>> hw/rtl/pse_checker.sv
// ----------------------------------------------------------------------------
// pse_checker
// Port-level checks on the encoder output stream.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pse_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_run_last,
  input logic       out_file_end
);

  `ASSERT_ALWAYS(a_idle_after_reset, clk, !rst_n |=> !out_valid)
  `ASSERT_ON(a_end_is_last, clk, rst_n, out_valid && out_file_end |-> out_run_last)
  `ASSERT_ON(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_run_last) && $stable(out_file_end))

endmodule

bind png_stored_rgb_encoder pse_checker u_pse_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_byte     (out_byte),
  .out_run_last (out_run_last),
  .out_file_end (out_file_end)
);
